[rtl/core/tgc_pkg.sv]
`default_nettype none

package tgc_pkg;

  // Geometry and time widths
  localparam int COORD_BITS = 12;
  localparam int TIME_BITS  = 32;
  localparam int FRAC_BITS  = 16;
  localparam int SIZE_BITS  = 13;
  localparam int MS_BITS    = 16;
  localparam int SQ_BITS    = 2 * COORD_BITS;

  // Stream packing
  localparam int IN_FIELD_BITS  = 2 * FRAC_BITS + 1 + TIME_BITS;
  localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int KIND_BITS      = 3;

  // Configuration port
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 16;

  // Register reset values
  localparam logic [SIZE_BITS-1:0]  WIDTH_RESET  = SIZE_BITS'(800);
  localparam logic [SIZE_BITS-1:0]  HEIGHT_RESET = SIZE_BITS'(480);
  localparam logic [MS_BITS-1:0]    TAP_RESET    = MS_BITS'(300);
  localparam logic [MS_BITS-1:0]    LONG_RESET   = MS_BITS'(600);
  localparam logic [COORD_BITS-1:0] LIMIT_RESET  = COORD_BITS'(25);
  localparam logic [COORD_BITS-1:0] SWIPE_RESET  = COORD_BITS'(60);
  localparam logic [SQ_BITS-1:0]    LIMIT_SQ_RESET = SQ_BITS'(25 * 25);
  localparam logic [SQ_BITS-1:0]    SWIPE_SQ_RESET = SQ_BITS'(60 * 60);

  // Queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [TIME_BITS-1:0]  stamp_t;

  typedef enum logic [KIND_BITS-1:0] {
    CMD_FINGER_DOWN   = 3'd0,
    CMD_MOUSE_DOWN    = 3'd1,
    CMD_FINGER_MOTION = 3'd2,
    CMD_MOUSE_MOTION  = 3'd3,
    CMD_RELEASE       = 3'd4,
    CMD_TICK          = 3'd5
  } cmd_t;

  typedef enum logic [KIND_BITS-1:0] {
    GEST_NONE  = 3'd0,
    GEST_TAP   = 3'd1,
    GEST_LONG  = 3'd2,
    GEST_UP    = 3'd3,
    GEST_DOWN  = 3'd4,
    GEST_LEFT  = 3'd5,
    GEST_RIGHT = 3'd6
  } gesture_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_PRESS,
    OP_MOTION,
    OP_RELEASE,
    OP_TICK
  } op_kind_t;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_TAP    = 3'd2,
    REG_LONG   = 3'd3,
    REG_LIMIT  = 3'd4,
    REG_SWIPE  = 3'd5
  } reg_idx_t;

  // Decoded event handed from front to back
  typedef struct packed {
    op_kind_t kind;
    coord_t   x;
    coord_t   y;
    stamp_t   stamp;
  } op_t;

  // Live configuration, distances kept squared
  typedef struct packed {
    logic [SIZE_BITS-1:0] win_w;
    logic [SIZE_BITS-1:0] win_h;
    logic [MS_BITS-1:0]   tap_max;
    logic [MS_BITS-1:0]   long_press;
    logic [SQ_BITS-1:0]   limit_sq;
    logic [SQ_BITS-1:0]   swipe_sq;
  } cfg_t;

endpackage

`default_nettype wire

[rtl/core/touch_gesture_classifier_top.sv]
// A word accepted on the input is written into the queue and, once the back end
// pops it, registered into the output word. Throughput: 1 word per cycle while
// the output is not stalled; the back end executes one event per cycle and a
// 4-entry queue absorbs output stalls before the input is held off.
// Reset: rst is synchronous, active high; it empties the queue, clears press
// state and the output valid, and loads the default register values.
`default_nettype none

module touch_gesture_classifier_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [tgc_pkg::IN_TDATA_BITS-1:0] s_tdata,   // pos_x, pos_y, left_button, time_ms
  input  wire logic [tgc_pkg::KIND_BITS-1:0]     s_tuser,   // command
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [tgc_pkg::OUT_TDATA_BITS-1:0]     m_tdata,   // gesture_x, gesture_y
  output logic [tgc_pkg::KIND_BITS-1:0]          m_tuser,   // gesture
  input  wire logic                              cfg_we,
  input  wire logic [tgc_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  wire logic [tgc_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);
  import tgc_pkg::*;

  cfg_t   cfg;
  coord_t cfg_coord;
  logic   push, full, pop, empty;
  op_t    push_op, head;

  assign cfg_coord = cfg_wdata[COORD_BITS-1:0];

  // Configuration registers, distance limits stored squared
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.win_w      <= WIDTH_RESET;
      cfg.win_h      <= HEIGHT_RESET;
      cfg.tap_max    <= TAP_RESET;
      cfg.long_press <= LONG_RESET;
      cfg.limit_sq   <= LIMIT_SQ_RESET;
      cfg.swipe_sq   <= SWIPE_SQ_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_WIDTH:  cfg.win_w      <= cfg_wdata[SIZE_BITS-1:0];
        REG_HEIGHT: cfg.win_h      <= cfg_wdata[SIZE_BITS-1:0];
        REG_TAP:    cfg.tap_max    <= cfg_wdata[MS_BITS-1:0];
        REG_LONG:   cfg.long_press <= cfg_wdata[MS_BITS-1:0];
        REG_LIMIT:  cfg.limit_sq   <= cfg_coord * cfg_coord;
        REG_SWIPE:  cfg.swipe_sq   <= cfg_coord * cfg_coord;
        default: ;
      endcase
    end
  end

  tgc_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cfg      (cfg),
    .full     (full),
    .push     (push),
    .push_op  (push_op)
  );

  tgc_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (full),
    .pop     (pop),
    .empty   (empty),
    .head    (head)
  );

  tgc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .op_valid (!empty),
    .op       (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

[rtl/core/tgc_front.sv]
`default_nettype none

module tgc_front (
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [tgc_pkg::IN_TDATA_BITS-1:0] s_tdata,  // pos_x, pos_y, left_button, time_ms
  input  wire logic [tgc_pkg::KIND_BITS-1:0]     s_tuser,  // command
  input  wire tgc_pkg::cfg_t                     cfg,
  input  wire logic                              full,
  output logic                                   push,
  output tgc_pkg::op_t                           push_op
);
  import tgc_pkg::*;

  localparam logic [FRAC_BITS-1:0] COORD_MAX = FRAC_BITS'((1 << COORD_BITS) - 1);

  logic [FRAC_BITS-1:0]           pos_x, pos_y;
  logic                           left;
  stamp_t                         stamp;
  logic [FRAC_BITS+SIZE_BITS-1:0] prod_x, prod_y;
  coord_t                         finger_x, finger_y, mouse_x, mouse_y;

  function automatic coord_t sat_coord(input logic [FRAC_BITS-1:0] v);
    return (v > COORD_MAX) ? COORD_MAX[COORD_BITS-1:0] : v[COORD_BITS-1:0];
  endfunction

  // Unpack word
  assign pos_x = s_tdata[FRAC_BITS-1:0];
  assign pos_y = s_tdata[2*FRAC_BITS-1:FRAC_BITS];
  assign left  = s_tdata[2*FRAC_BITS];
  assign stamp = s_tdata[2*FRAC_BITS+TIME_BITS:2*FRAC_BITS+1];

  // Finger fractions scaled to window pixels, truncated then saturated
  assign prod_x   = pos_x * cfg.win_w;
  assign prod_y   = pos_y * cfg.win_h;
  assign finger_x = sat_coord(FRAC_BITS'(prod_x[FRAC_BITS+SIZE_BITS-1:FRAC_BITS]));
  assign finger_y = sat_coord(FRAC_BITS'(prod_y[FRAC_BITS+SIZE_BITS-1:FRAC_BITS]));
  assign mouse_x  = sat_coord(pos_x);
  assign mouse_y  = sat_coord(pos_y);

  assign s_tready = !full;
  assign push     = s_tvalid && !full;

  // Classify the event
  always_comb begin
    push_op.kind  = OP_NOP;
    push_op.x     = finger_x;
    push_op.y     = finger_y;
    push_op.stamp = stamp;
    case (s_tuser)
      CMD_FINGER_DOWN:   push_op.kind = OP_PRESS;
      CMD_FINGER_MOTION: push_op.kind = OP_MOTION;
      CMD_MOUSE_DOWN: begin
        push_op.kind = left ? OP_PRESS : OP_NOP;
        push_op.x    = mouse_x;
        push_op.y    = mouse_y;
      end
      CMD_MOUSE_MOTION: begin
        push_op.kind = left ? OP_MOTION : OP_NOP;
        push_op.x    = mouse_x;
        push_op.y    = mouse_y;
      end
      CMD_RELEASE:       push_op.kind = OP_RELEASE;
      CMD_TICK:          push_op.kind = OP_TICK;
      default:           push_op.kind = OP_NOP;
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/tgc_fifo.sv]
`default_nettype none

module tgc_fifo (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire tgc_pkg::op_t push_op,
  output logic              full,
  input  wire logic         pop,
  output logic              empty,
  output tgc_pkg::op_t      head
);
  import tgc_pkg::*;

  op_t                      slots [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [FIFO_CNT_BITS-1:0] count;

  assign full  = (count == FIFO_CNT_BITS'(FIFO_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_op;
  end

endmodule

`default_nettype wire

[rtl/core/tgc_back.sv]
`default_nettype none

module tgc_back (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire tgc_pkg::cfg_t                      cfg,
  input  wire logic                               op_valid,
  input  wire tgc_pkg::op_t                       op,
  output logic                                    pop,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  output logic [tgc_pkg::OUT_TDATA_BITS-1:0]      m_tdata,  // gesture_x, gesture_y
  output logic [tgc_pkg::KIND_BITS-1:0]           m_tuser   // gesture
);
  import tgc_pkg::*;

  // Press tracking state
  logic   pressed, pressed_next;
  logic   long_fired, long_fired_next;
  stamp_t press_time, press_time_next;
  coord_t press_x, press_x_next, press_y, press_y_next;
  coord_t now_x, now_x_next, now_y, now_y_next;

  // Result register
  gesture_t out_gesture, gesture;
  coord_t   out_x, out_y;

  logic signed [COORD_BITS:0]     dx, dy, ax, ay;
  logic signed [2*COORD_BITS+1:0] dx_prod, dy_prod;
  logic [SQ_BITS:0]               d2;
  stamp_t                         held;
  logic                           tap_ok, swipe_ok, long_ok;

  assign pop = op_valid && (!m_tvalid || m_tready);

  // Displacement, squared distance and held time
  assign dx      = $signed({1'b0, now_x}) - $signed({1'b0, press_x});
  assign dy      = $signed({1'b0, now_y}) - $signed({1'b0, press_y});
  assign ax      = dx[COORD_BITS] ? -dx : dx;
  assign ay      = dy[COORD_BITS] ? -dy : dy;
  assign dx_prod = dx * dx;
  assign dy_prod = dy * dy;
  assign d2      = {1'b0, dx_prod[SQ_BITS-1:0]} + {1'b0, dy_prod[SQ_BITS-1:0]};
  assign held    = op.stamp - press_time;

  assign tap_ok   = (d2 < {1'b0, cfg.limit_sq}) && (held < TIME_BITS'(cfg.tap_max));
  assign swipe_ok = (d2 >= {1'b0, cfg.swipe_sq});
  assign long_ok  = (held >= TIME_BITS'(cfg.long_press)) && (d2 <= {1'b0, cfg.limit_sq});

  // Event execution
  always_comb begin
    pressed_next    = pressed;
    long_fired_next = long_fired;
    press_time_next = press_time;
    press_x_next    = press_x;
    press_y_next    = press_y;
    now_x_next      = now_x;
    now_y_next      = now_y;
    gesture         = GEST_NONE;
    case (op.kind)
      OP_PRESS: begin
        pressed_next    = 1'b1;
        long_fired_next = 1'b0;
        press_time_next = op.stamp;
        press_x_next    = op.x;
        press_y_next    = op.y;
        now_x_next      = op.x;
        now_y_next      = op.y;
      end
      OP_MOTION: begin
        if (pressed) begin
          now_x_next = op.x;
          now_y_next = op.y;
        end
      end
      OP_RELEASE: begin
        if (pressed) begin
          pressed_next = 1'b0;
          if (!long_fired) begin
            if (tap_ok) begin
              gesture = GEST_TAP;
            end else if (swipe_ok) begin
              // vertical only when strictly dominant
              if (ay > ax) gesture = dy[COORD_BITS] ? GEST_UP : GEST_DOWN;
              else         gesture = dx[COORD_BITS] ? GEST_LEFT : GEST_RIGHT;
            end
          end
        end
      end
      OP_TICK: begin
        if (pressed && !long_fired && long_ok) begin
          long_fired_next = 1'b1;
          gesture         = GEST_LONG;
        end
      end
      default: ;
    endcase
  end

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      pressed    <= 1'b0;
      long_fired <= 1'b0;
      press_time <= '0;
      press_x    <= '0;
      press_y    <= '0;
      now_x      <= '0;
      now_y      <= '0;
    end else if (pop) begin
      pressed    <= pressed_next;
      long_fired <= long_fired_next;
      press_time <= press_time_next;
      press_x    <= press_x_next;
      press_y    <= press_y_next;
      now_x      <= now_x_next;
      now_y      <= now_y_next;
    end
  end

  // Output word valid
  always_ff @(posedge clk) begin
    if (rst)           m_tvalid <= 1'b0;
    else if (pop)      m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  // Output word payload, position zero with no gesture
  always_ff @(posedge clk) begin
    if (pop) begin
      out_gesture <= gesture;
      out_x       <= (gesture == GEST_NONE) ? '0 : press_x;
      out_y       <= (gesture == GEST_NONE) ? '0 : press_y;
    end
  end

  assign m_tuser = out_gesture;
  assign m_tdata = OUT_TDATA_BITS'({out_y, out_x});

endmodule

`default_nettype wire

[rtl/core/tgc_checker.sv]
`default_nettype none

module tgc_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               m_tvalid,
  input wire logic                               m_tready,
  input wire logic [tgc_pkg::OUT_TDATA_BITS-1:0] m_tdata,
  input wire logic [tgc_pkg::KIND_BITS-1:0]      m_tuser
);
  import tgc_pkg::*;

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed while stalled");

  // No gesture means zero position
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == GEST_NONE) |-> (m_tdata == '0))
    else $error("position reported without a gesture");

  // Gesture code within the defined set
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser <= GEST_RIGHT))
    else $error("undefined gesture code");

  // Output empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output word valid after reset");

endmodule

bind touch_gesture_classifier_top tgc_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
